// File: hdl/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types and constants for the commented-JSON stripper.
// ----------------------------------------------------------------------------
package jcs_pkg;

  localparam int DEPTH_BITS = 16;   // nesting counter width
  localparam int OBUF_DEPTH = 4;    // result buffer entries
  localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STRING = 3'd4,
    MODE_DONE   = 3'd5
  } scan_mode_t;

endpackage

// File: hdl/jcs_if.sv
// ----------------------------------------------------------------------------
// jcs_if
// Valid/ready channels for text bytes in and filtered bytes out.
// ----------------------------------------------------------------------------
interface jcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jcs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hdl/jsonc_comment_stripper.sv
// ----------------------------------------------------------------------------
// jsonc_comment_stripper
// Streaming filter: blanks comments, in-string line breaks and trailing text
// after the root value closes, keeping the text length.
// ----------------------------------------------------------------------------
//  channel   dir  payload             item
//  in_ch     in   in_byte, in_last    one text byte
//  out_ch    out  out_byte, out_last  one filtered byte
//
//  One text byte enters per cycle while in_ch.ready is high. It is
//  registered, then scanned, and its 0..2 result bytes land in a 4-entry
//  result buffer. The input register advances while the buffer holds at
//  most two bytes. A held slash yields nothing and its follower two, so the
//  pair gives two bytes and the input never waits on an unstalled output.
//  rst_n is synchronous, active low; it clears scan state and the buffer.
//  A stalled out_ch backs up through the buffer into in_ch.ready.
module jsonc_comment_stripper (
  input  logic      clk,
  input  logic      rst_n,
  jcs_in_if.sink    in_ch,
  jcs_out_if.source out_ch
);
  import jcs_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  // input register
  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_last_r;
  logic       stg_fire;
  logic       in_take;

  // scan state
  scan_mode_t            mode_r, mode_nxt;
  logic                  bslash_r, bslash_nxt;
  logic                  star_r, star_nxt;
  logic                  root_r, root_nxt;
  logic [DEPTH_BITS-1:0] brace_r, brace_nxt;
  logic [DEPTH_BITS-1:0] bracket_r, bracket_nxt;

  // results of the current byte
  logic [1:0] res_n;
  logic [7:0] res_b0, res_b1;

  // result buffer
  logic [7:0]         obuf_byte_r [OBUF_DEPTH];
  logic               obuf_last_r [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr1;
  logic [OBUF_CW-1:0] cnt_r;
  logic               pop;
  logic [1:0]         push_n;

  // room for two results regardless of this cycle's pop
  assign stg_fire = stg_valid_r && (cnt_r <= OBUF_CW'(OBUF_DEPTH - 2));
  assign in_ch.ready = !stg_valid_r || stg_fire;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
    if (in_take) begin
      stg_byte_r <= in_ch.in_byte;
      stg_last_r <= in_ch.in_last;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    bslash_nxt  = bslash_r;
    star_nxt    = star_r;
    root_nxt    = root_r;
    brace_nxt   = brace_r;
    bracket_nxt = bracket_r;
    res_n       = 2'd1;
    res_b0      = stg_byte_r;
    res_b1      = stg_byte_r;

    unique case (mode_r)
      MODE_SLASH: begin
        res_n = 2'd2;
        if (stg_byte_r == CH_SLASH) begin
          res_b0   = CH_SPACE;
          res_b1   = CH_SPACE;
          mode_nxt = MODE_LINE;
        end else if (stg_byte_r == CH_STAR) begin
          res_b0   = CH_SPACE;
          res_b1   = CH_SPACE;
          star_nxt = 1'b0;
          mode_nxt = MODE_BLOCK;
        end else begin
          // lone slash: follower passes unexamined
          res_b0   = CH_SLASH;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        res_b0 = CH_SPACE;
        if (stg_byte_r == CH_NEWLINE) mode_nxt = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        res_b0 = CH_SPACE;
        if (star_r && stg_byte_r == CH_SLASH) begin
          star_nxt = 1'b0;
          mode_nxt = MODE_NORMAL;
        end else begin
          star_nxt = (stg_byte_r == CH_STAR);
        end
      end
      MODE_STRING: begin
        if (stg_byte_r == CH_QUOTE && !bslash_r) begin
          bslash_nxt = 1'b0;
          mode_nxt   = MODE_NORMAL;
        end else begin
          if (stg_byte_r == CH_NEWLINE || stg_byte_r == CH_CR) res_b0 = CH_SPACE;
          bslash_nxt = (stg_byte_r == CH_BACKSLASH);
        end
      end
      MODE_DONE: begin
        res_b0 = CH_SPACE;
      end
      default: begin
        if (stg_byte_r == CH_SLASH) begin
          if (!stg_last_r) begin
            res_n    = 2'd0;
            mode_nxt = MODE_SLASH;
          end
        end else if (stg_byte_r == CH_LBRACE) begin
          if (!root_r) root_nxt = 1'b1;
          else if (brace_r != DEPTH_MAX) brace_nxt = brace_r + 1'b1;
        end else if (stg_byte_r == CH_LBRACKET) begin
          if (!root_r) root_nxt = 1'b1;
          else if (bracket_r != DEPTH_MAX) bracket_nxt = bracket_r + 1'b1;
        end else if (stg_byte_r == CH_RBRACE) begin
          if (brace_r == '0) mode_nxt = MODE_DONE;
          else brace_nxt = brace_r - 1'b1;
        end else if (stg_byte_r == CH_RBRACKET) begin
          if (bracket_r == '0) mode_nxt = MODE_DONE;
          else bracket_nxt = bracket_r - 1'b1;
        end else if (stg_byte_r == CH_QUOTE) begin
          bslash_nxt = 1'b0;
          mode_nxt   = MODE_STRING;
        end
      end
    endcase

    // end of text: next byte starts fresh
    if (stg_last_r) begin
      mode_nxt    = MODE_NORMAL;
      bslash_nxt  = 1'b0;
      star_nxt    = 1'b0;
      root_nxt    = 1'b0;
      brace_nxt   = '0;
      bracket_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      bslash_r  <= 1'b0;
      star_r    <= 1'b0;
      root_r    <= 1'b0;
      brace_r   <= '0;
      bracket_r <= '0;
    end else if (stg_fire) begin
      mode_r    <= mode_nxt;
      bslash_r  <= bslash_nxt;
      star_r    <= star_nxt;
      root_r    <= root_nxt;
      brace_r   <= brace_nxt;
      bracket_r <= bracket_nxt;
    end
  end

  // result buffer
  assign push_n  = stg_fire ? res_n : 2'd0;
  assign pop     = out_ch.valid && out_ch.ready;
  assign wr_ptr1 = wr_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OBUF_AW'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + OBUF_CW'(push_n) - OBUF_CW'(pop);
    end
    if (push_n != 2'd0) begin
      obuf_byte_r[wr_ptr_r] <= res_b0;
      obuf_last_r[wr_ptr_r] <= stg_last_r && (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      obuf_byte_r[wr_ptr1] <= res_b1;
      obuf_last_r[wr_ptr1] <= stg_last_r;
    end
  end

  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.out_byte = obuf_byte_r[rd_ptr_r];
  assign out_ch.out_last = obuf_last_r[rd_ptr_r];

endmodule
